/* src/tup_pkg.sv */
package tup_pkg;

  // Parse phase of the string that is being read.
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_ZERO   = 2'd2,
    PH_DIGITS = 2'd3
  } tup_phase_t;

  // Parse state that is carried from one word to the next (the accumulator is apart).
  typedef struct packed {
    tup_phase_t  phase;
    logic        negative;
    logic        failed;
    logic [4:0]  active_base;
  } tup_state_t;

  // Character codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_O  = 8'h6F;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Bases.
  localparam logic [4:0] BASE_AUTO = 5'd0;
  localparam logic [4:0] BASE_BIN  = 5'd2;
  localparam logic [4:0] BASE_OCT  = 5'd8;
  localparam logic [4:0] BASE_DEC  = 5'd10;
  localparam logic [4:0] BASE_HEX  = 5'd16;

  // Reset value of the radix register.
  localparam logic [4:0] RADIX_RESET = BASE_DEC;

  // Digit value 0 to 15 of a character, or 16 for anything that is no digit.
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd16;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h61 + 8'd10;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h41 + 8'd10;
    end
    return d[4:0];
  endfunction

endpackage

/* src/tup_in_stage.sv */
module tup_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       last,
  input  logic       advance,
  output logic       hold_valid,
  output logic [7:0] hold_char,
  output logic       hold_last
);

  // The register may take a new word when it is empty or is emptied in this cycle.
  assign in_ready = !hold_valid || advance;

  // Valid flag of the held word.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // Payload of the held word.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_char <= char_code;
      hold_last <= last;
    end
  end

endmodule

/* src/tup_step.sv */
module tup_step #(
  parameter int VALUE_BITS = 16
) (
  input  tup_pkg::tup_state_t    st,
  input  logic [VALUE_BITS-1:0]  accum,
  input  logic [7:0]             c,
  input  logic                   is_last,
  input  logic [4:0]             radix,
  output tup_pkg::tup_state_t    st_next,
  output logic [VALUE_BITS-1:0]  accum_next,
  output logic [15:0]            res_value,
  output logic                   res_ok
);
  import tup_pkg::*;

  tup_phase_t            ph;
  logic [4:0]            base;
  logic                  neg;
  logic                  fail;
  logic                  take;
  logic                  consumed;
  logic [7:0]            c_lc;
  logic [4:0]            dig;
  logic                  digit_bad;
  logic [VALUE_BITS+4:0] prod;
  logic [VALUE_BITS+5:0] sum;
  logic                  ovf;
  logic [VALUE_BITS-1:0] acc_new;
  logic                  fail_new;
  logic                  ok;
  logic [VALUE_BITS+15:0] acc_wide;

  assign c_lc = c | CASE_BIT;

  // Sign, leading zero and prefix handling.
  always_comb begin
    ph       = st.phase;
    base     = st.active_base;
    neg      = st.negative;
    fail     = st.failed;
    take     = 1'b0;
    consumed = 1'b0;
    if (!st.failed) begin
      if (ph == PH_START) begin
        base = radix;
        if (c == CH_PLUS || c == CH_MINUS) begin
          neg      = (c == CH_MINUS);
          consumed = 1'b1;
        end
        ph = PH_SIGN;
      end
      if (!consumed) begin
        unique case (ph)
          PH_START: begin
            take = 1'b0;
          end
          PH_SIGN: begin
            if (c == CH_ZERO) begin
              ph = PH_ZERO;
            end else begin
              if (base == BASE_AUTO) begin
                base = BASE_DEC;
              end
              ph   = PH_DIGITS;
              take = 1'b1;
            end
          end
          PH_ZERO: begin
            ph = PH_DIGITS;
            if (base == BASE_AUTO) begin
              if (c_lc == CH_LC_X) begin
                base = BASE_HEX;
              end else if (c_lc == CH_LC_B) begin
                base = BASE_BIN;
              end else if (c_lc == CH_LC_O) begin
                base = BASE_OCT;
              end else if (c >= CH_ZERO && c <= CH_NINE) begin
                base = BASE_DEC;
                take = 1'b1;
              end else begin
                fail = 1'b1;
              end
            end else begin
              take = 1'b1;
            end
          end
          PH_DIGITS: begin
            take = 1'b1;
          end
        endcase
      end
    end
  end

  // Digit check and multiply-accumulate with an overflow test.
  assign dig       = digit_of(c);
  assign digit_bad = dig[4] || (dig >= base) || (base == BASE_AUTO);
  assign prod      = accum * base;
  assign sum       = {1'b0, prod} + (VALUE_BITS+6)'(dig);
  assign ovf       = |sum[VALUE_BITS+5:VALUE_BITS];

  always_comb begin
    acc_new  = accum;
    fail_new = fail;
    if (take) begin
      if (digit_bad || ovf) begin
        fail_new = 1'b1;
      end else begin
        acc_new = sum[VALUE_BITS-1:0];
      end
    end
  end

  // Result of a final word; a negative zero is accepted.
  assign ok = !fail_new && ph != PH_SIGN && ph != PH_START && !(neg && acc_new != '0);
  assign acc_wide  = {16'b0, acc_new};
  assign res_ok    = ok;
  assign res_value = ok ? acc_wide[15:0] : 16'b0;

  // The state returns to its start after the final word of a string.
  always_comb begin
    if (is_last) begin
      st_next.phase       = PH_START;
      st_next.negative    = 1'b0;
      st_next.failed      = 1'b0;
      st_next.active_base = BASE_AUTO;
      accum_next          = '0;
    end else begin
      st_next.phase       = ph;
      st_next.negative    = neg;
      st_next.failed      = fail_new;
      st_next.active_base = base;
      accum_next          = acc_new;
    end
  end

endmodule

/* src/text_to_u16_parser_top.sv */
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    char_code[7:0], last
// result    out        out_valid / out_ready  value[15:0], ok
// config    in         cfg_write_en           cfg_write_data[4:0] (radix)
//
// One character word is taken each cycle unless a held final word waits on a full
// result register. The parse step sits between the input register and the state
// and result registers, so a final word passes the input register and then the
// result register. Reset (rst, synchronous) empties both registers, sets the radix
// to ten and clears the parse state.
// A result waiting on out_ready stalls only a later final word; other words go on.
module text_to_u16_parser_top #(
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] value,
  output logic        ok,
  input  logic        cfg_write_en,
  input  logic [4:0]  cfg_write_data
);
  import tup_pkg::*;

  logic                  hold_valid;
  logic [7:0]            hold_char;
  logic                  hold_last;
  logic                  advance;
  logic [4:0]            radix;
  tup_state_t            st;
  tup_state_t            st_next;
  logic [VALUE_BITS-1:0] accum;
  logic [VALUE_BITS-1:0] accum_next;
  logic [15:0]           res_value;
  logic                  res_ok;

  // Input register.
  tup_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .last      (last),
    .advance   (advance),
    .hold_valid(hold_valid),
    .hold_char (hold_char),
    .hold_last (hold_last)
  );

  // One parse step on the held word.
  tup_step #(
    .VALUE_BITS(VALUE_BITS)
  ) u_step (
    .st        (st),
    .accum     (accum),
    .c         (hold_char),
    .is_last   (hold_last),
    .radix     (radix),
    .st_next   (st_next),
    .accum_next(accum_next),
    .res_value (res_value),
    .res_ok    (res_ok)
  );

  // A held word moves on unless it is final and the result register is still full.
  assign advance = hold_valid && (!hold_last || !out_valid || out_ready);

  // Radix register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_write_en) begin
      radix <= cfg_write_data;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= PH_START;
      st.negative    <= 1'b0;
      st.failed      <= 1'b0;
      st.active_base <= BASE_AUTO;
      accum          <= '0;
    end else if (advance) begin
      st    <= st_next;
      accum <= accum_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hold_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_last) begin
      value <= res_value;
      ok    <= res_ok;
    end
  end

  // A failed parse never reports a value.
  assert property (@(posedge clk) disable iff (rst) out_valid && !ok |-> value == 16'b0)
    else $error("failed result carries a nonzero value");

  // The parse state is back at its start after a final word.
  assert property (@(posedge clk) disable iff (rst)
    advance && hold_last |=> st.phase == PH_START && accum == '0 && !st.failed)
    else $error("parse state not cleared after final word");

  // A new result is only loaded from a final word.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && hold_last))
    else $error("result appeared without a final word");

  // A held word that cannot move on is kept.
  assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid && $stable(hold_char) && $stable(hold_last))
    else $error("held word lost while stalled");

  // Once a string has failed, the accumulator no longer changes.
  assert property (@(posedge clk) disable iff (rst)
    st.failed && advance && !hold_last |=> $stable(accum) && st.failed)
    else $error("accumulator changed after a failure");

endmodule

/* dv/tb_top.sv */
module tb_top;
  import tup_pkg::*;

  localparam int ITEMS          = 1550;
  localparam int QUIET_WORDS    = 200;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int VALUE_MAX      = 65535;
  localparam int DIR_ROWS       = 15;

  // One expected result of a parsed string.
  typedef struct packed {
    logic [15:0] value;
    logic        ok;
  } parse_result_t;

  // One directed string: the radix it runs under, its text and, where it is
  // obvious, the result typed in by hand.
  typedef struct packed {
    logic [4:0]  rdx;
    logic [3:0]  len;
    logic [63:0] text;
    logic        known;
    logic [15:0] value;
    logic        ok;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code = 8'h00;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] value;
  logic        ok;
  logic        cfg_write_en = 1'b0;
  logic [4:0]  cfg_write_data = 5'd0;

  // Hand-typed expectation that travels alongside the word it belongs to.
  logic        tag_known = 1'b0;
  logic [15:0] tag_value = 16'd0;
  logic        tag_ok = 1'b0;

  // Copy of the parser state kept by the predictor.
  logic [4:0]  radix_q;
  tup_phase_t  phase_q;
  logic        neg_q;
  logic [15:0] accum_q;
  logic [4:0]  base_q;
  logic        failed_q;

  parse_result_t due_results[$];
  dir_row_t      dir_table [DIR_ROWS];

  int   failures = 0;
  int   words_sent = 0;
  int   idle_cycles = 0;
  int   gap_pct = 20;
  bit   quiet = 1'b0;
  logic [4:0] cur_radix = RADIX_RESET;
  int   ready_left = 0;

  text_to_u16_parser_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_code      (char_code),
    .last           (last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value          (value),
    .ok             (ok),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always #5 clk = ~clk;

  // Digit value of a character, 16 when it is no digit at all.
  function automatic int digit_val(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return 16;
  endfunction

  // Character for a digit value, letters in a random case.
  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return 8'(CH_ZERO + d);
    if ($urandom_range(1) != 0) return 8'("a" + d - 10);
    return 8'("A" + d - 10);
  endfunction

  function automatic void clear_parse();
    phase_q  = PH_START;
    neg_q    = 1'b0;
    accum_q  = 16'd0;
    base_q   = BASE_AUTO;
    failed_q = 1'b0;
  endfunction

  // Fold one digit into the accumulator, failing on a bad digit or overflow.
  function automatic void fold_digit(input logic [7:0] c);
    int d;
    int b;
    d = digit_val(c);
    b = int'(base_q);
    if (d >= 16 || d >= b || b == 0) begin
      failed_q = 1'b1;
      return;
    end
    if ((VALUE_MAX - d) / b < int'(accum_q)) begin
      failed_q = 1'b1;
      return;
    end
    accum_q = 16'(int'(accum_q) * b + d);
  endfunction

  // Advance the parse by one character; returns 1 when a result is due.
  function automatic bit parse_char(input logic [7:0] c, input logic fin,
                                    output parse_result_t res);
    bit         consumed;
    logic [7:0] lc;
    consumed = 1'b0;
    res = '0;
    lc = c | CASE_BIT;
    if (!failed_q) begin
      if (phase_q == PH_START) begin
        base_q  = radix_q;
        phase_q = PH_SIGN;
        if (c == CH_PLUS || c == CH_MINUS) begin
          neg_q    = (c == CH_MINUS);
          consumed = 1'b1;
        end
      end
      if (!consumed) begin
        case (phase_q)
          PH_SIGN: begin
            if (c == CH_ZERO) begin
              phase_q = PH_ZERO;
            end else begin
              if (base_q == BASE_AUTO) base_q = BASE_DEC;
              phase_q = PH_DIGITS;
              fold_digit(c);
            end
          end
          PH_ZERO: begin
            phase_q = PH_DIGITS;
            if (base_q == BASE_AUTO) begin
              // Prefix detection after a leading zero.
              if (lc == CH_LC_X) begin
                base_q = BASE_HEX;
              end else if (lc == CH_LC_B) begin
                base_q = BASE_BIN;
              end else if (lc == CH_LC_O) begin
                base_q = BASE_OCT;
              end else if (c >= CH_ZERO && c <= CH_NINE) begin
                base_q = BASE_DEC;
                fold_digit(c);
              end else begin
                failed_q = 1'b1;
              end
            end else begin
              fold_digit(c);
            end
          end
          default: begin
            fold_digit(c);
          end
        endcase
      end
    end
    if (!fin) return 1'b0;
    res.ok = !failed_q && phase_q != PH_SIGN && phase_q != PH_START;
    if (neg_q && accum_q != 16'd0) res.ok = 1'b0;
    res.value = res.ok ? accum_q : 16'd0;
    clear_parse();
    return 1'b1;
  endfunction

  // Predictor and checker: both sample the handshakes at the clock edge.
  always @(posedge clk) begin
    parse_result_t res;
    parse_result_t exp_res;
    if (rst) begin
      radix_q = RADIX_RESET;
      clear_parse();
    end else begin
      if (cfg_write_en) radix_q = cfg_write_data;
      if (in_valid && in_ready) begin
        if (parse_char(char_code, last, res)) begin
          if (tag_known) begin
            res.value = tag_value;
            res.ok    = tag_ok;
          end
          due_results.push_back(res);
        end
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("unexpected result: value %0d ok %0b", value, ok);
          end
        end else begin
          exp_res = due_results.pop_front();
          if (value !== exp_res.value || ok !== exp_res.ok) begin
            failures++;
            if (failures <= 10) begin
              $display("result mismatch: value exp %0d got %0d, ok exp %0b got %0b",
                       exp_res.value, value, exp_res.ok, ok);
            end
          end
        end
      end
    end
  end

  // Result side: bursts of stall between stretches of readiness.
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if ($urandom_range(3) == 0) begin
      ready_left = $urandom_range(10, 1) - 1;
      out_ready <= 1'b0;
    end else begin
      ready_left = $urandom_range(30, 1) - 1;
      out_ready <= 1'b1;
    end
  end

  // Watchdog over cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one character word, after a random gap, and wait for its acceptance.
  task automatic send_word(input logic [7:0] c, input logic fin, input logic known,
                           input logic [15:0] exp_value, input logic exp_ok);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < gap_pct) gap = $urandom_range(10, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last      <= fin;
    tag_known <= known;
    tag_value <= exp_value;
    tag_ok    <= exp_ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Hold the sender until every result has come and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_radix(input logic [4:0] r);
    wait_idle();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= r;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cur_radix = r;
  endtask

  // A random string: mostly well-formed numbers for the current radix, with
  // some broken ones and some plain noise.
  task automatic send_random_string();
    logic [7:0] s[$];
    int         base;
    int         lim;
    int         ndig;
    int         pick;
    bit         prefixed;
    pick = $urandom_range(99);
    prefixed = 1'b0;
    if (pick < 12) begin
      repeat ($urandom_range(6, 1)) s.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(3) == 0) s.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
      base = int'(cur_radix);
      if (cur_radix == BASE_AUTO) begin
        // Choose how the base is announced.
        case ($urandom_range(4))
          0: begin
            s.push_back(CH_ZERO);
            s.push_back($urandom_range(1) ? CH_LC_X : (CH_LC_X & ~CASE_BIT));
            base = 16;
            prefixed = 1'b1;
          end
          1: begin
            s.push_back(CH_ZERO);
            s.push_back($urandom_range(1) ? CH_LC_B : (CH_LC_B & ~CASE_BIT));
            base = 2;
            prefixed = 1'b1;
          end
          2: begin
            s.push_back(CH_ZERO);
            s.push_back($urandom_range(1) ? CH_LC_O : (CH_LC_O & ~CASE_BIT));
            base = 8;
            prefixed = 1'b1;
          end
          3: begin
            s.push_back(CH_ZERO);
            base = 10;
            prefixed = 1'b1;
          end
          default: begin
            base = 10;
          end
        endcase
      end else if ($urandom_range(9) == 0) begin
        // A prefix under a fixed base is read as digits.
        s.push_back(CH_ZERO);
        s.push_back(CH_LC_X);
        prefixed = 1'b1;
      end
      lim = (base > 16) ? 16 : base;
      if ($urandom_range(7) == 0) ndig = $urandom_range(7, 5);
      else ndig = $urandom_range(4, 1);
      if ($urandom_range(19) == 0) ndig = 0;
      if (!prefixed && $urandom_range(1) == 0 && ndig > 0) begin
        s.push_back(digit_char($urandom_range(lim - 1, (lim > 1) ? 1 : 0)));
        ndig--;
      end
      repeat (ndig) s.push_back(digit_char($urandom_range(lim - 1)));
      if (s.size() == 0) s.push_back(CH_ZERO);
      if ($urandom_range(9) == 0) s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
    end
    foreach (s[i]) send_word(s[i], i == s.size() - 1, 1'b0, 16'd0, 1'b0);
  endtask

  initial begin
    dir_row_t row;
    int       phase_words;
    int       r;

    // Directed strings: boundaries, signs, prefixes and odd bases.
    dir_table[0]  = '{BASE_DEC,  4'd1, "0",     1'b1, 16'd0,     1'b1};
    dir_table[1]  = '{BASE_DEC,  4'd5, "65536", 1'b1, 16'd0,     1'b0};
    dir_table[2]  = '{BASE_DEC,  4'd1, "+",     1'b1, 16'd0,     1'b0};
    dir_table[3]  = '{BASE_DEC,  4'd2, "-0",    1'b1, 16'd0,     1'b1};
    dir_table[4]  = '{BASE_DEC,  4'd2, "-7",    1'b1, 16'd0,     1'b0};
    dir_table[5]  = '{BASE_DEC,  4'd1, 64'hFF,  1'b1, 16'd0,     1'b0};
    dir_table[6]  = '{BASE_DEC,  4'd1, 64'h00,  1'b1, 16'd0,     1'b0};
    dir_table[7]  = '{BASE_HEX,  4'd4, "FFFF",  1'b1, 16'd65535, 1'b1};
    dir_table[8]  = '{BASE_HEX,  4'd3, "0x1",   1'b1, 16'd0,     1'b0};
    dir_table[9]  = '{BASE_AUTO, 4'd2, "0x",    1'b1, 16'd0,     1'b1};
    dir_table[10] = '{BASE_AUTO, 4'd3, "0b1",   1'b0, 16'd0,     1'b0};
    dir_table[11] = '{BASE_AUTO, 4'd2, "0z",    1'b1, 16'd0,     1'b0};
    dir_table[12] = '{BASE_AUTO, 4'd1, "9",     1'b0, 16'd0,     1'b0};
    dir_table[13] = '{5'd1,      4'd1, "1",     1'b1, 16'd0,     1'b0};
    dir_table[14] = '{5'd31,     4'd1, "f",     1'b0, 16'd0,     1'b0};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, walked row by row.
    for (int k = 0; k < DIR_ROWS; k++) begin
      row = dir_table[k];
      if (row.rdx != cur_radix) set_radix(row.rdx);
      for (int i = 0; i < int'(row.len); i++) begin
        send_word(row.text[8 * (int'(row.len) - 1 - i) +: 8], i == int'(row.len) - 1,
                  row.known, row.value, row.ok);
      end
    end

    // Random part, in phases of one radix each with its own amount of idling.
    while (words_sent < ITEMS) begin
      r = $urandom_range(9);
      case (r)
        0, 1, 2: set_radix(BASE_AUTO);
        3:       set_radix(BASE_DEC);
        4:       set_radix(BASE_HEX);
        5:       set_radix(BASE_BIN);
        6:       set_radix(BASE_OCT);
        7:       set_radix($urandom_range(1) ? 5'd1 : 5'd31);
        default: set_radix(5'($urandom_range(31)));
      endcase
      case ($urandom_range(2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 35;
      endcase
      phase_words = words_sent + $urandom_range(120, 40);
      while (words_sent < phase_words && words_sent < ITEMS) begin
        if (words_sent >= ITEMS - QUIET_WORDS) quiet = 1'b1;
        send_random_string();
      end
    end

    // Drain and report.
    wait_idle();
    if (due_results.size() != 0) failures++;
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
